/* design/fqks_pkg.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key search - shared package
// Operation and status codes, sequencer states and the result record that
// passes from the controller to the output stage.
// ----------------------------------------------------------------------------
package fqks_pkg;

   localparam int unsigned OP_W       = 3;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned KEY_PORT_W = 32;
   localparam int unsigned DATA_PORT_W = 32;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned COUNT_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_SEARCH = 3'd4,
      OP_EDIT   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_PEEK,
      SQ_SEARCH
   } seq_state_type;

   typedef struct packed {
      status_type             status;
      logic [DATA_PORT_W-1:0] read_data;
      logic [COUNT_W-1:0]     entry_count;
   } result_type;

endpackage

/* design/fqks_ram.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key search - entry memory
// Simple dual-port memory of key and data pairs, one write port and one
// read port with the read data registered.
// ----------------------------------------------------------------------------
module fqks_ram
   import fqks_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned KEY_WIDTH  = 32,
   parameter int unsigned DATA_WIDTH = 32,
   localparam int unsigned PTR_W     = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PTR_W-1:0]      wr_addr,
   input  logic [KEY_WIDTH-1:0]  wr_key,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [PTR_W-1:0]      rd_addr,
   output logic [KEY_WIDTH-1:0]  rd_key,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [KEY_WIDTH+DATA_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH+DATA_WIDTH-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_data};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_key  = rd_q_ff[KEY_WIDTH+DATA_WIDTH-1:DATA_WIDTH];
   assign rd_data = rd_q_ff[DATA_WIDTH-1:0];

endmodule

/* design/fqks_ctrl.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key search - controller
// Holds the ring pointers and occupancy, decodes each transaction, drives
// the entry memory and walks it one entry per cycle for a search.
// ----------------------------------------------------------------------------
module fqks_ctrl
   import fqks_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned KEY_WIDTH  = 32,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [KEY_PORT_W-1:0]  req_entry_key,
   input  logic [DATA_PORT_W-1:0] req_entry_data,
   input  logic [POS_W-1:0]       req_position,
   input  logic                   rsp_free,
   output logic                   done,
   output result_type             result
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned OCC_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
   localparam int unsigned CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

   seq_state_type          state_ff, state_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [PTR_W-1:0]       scan_ff, scan_in;
   logic [OCC_W-1:0]       issued_ff, issued_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;

   logic                   wr_en;
   logic [PTR_W-1:0]       wr_addr;
   logic                   rd_en;
   logic [PTR_W-1:0]       rd_addr;
   logic [KEY_WIDTH-1:0]   rd_key;
   logic [DATA_WIDTH-1:0]  rd_data;

   logic [KEY_WIDTH-1:0]   req_key;
   logic [DATA_WIDTH-1:0]  req_data;
   logic [SUM_W-1:0]       edit_sum;
   logic [PTR_W-1:0]       edit_slot;
   logic                   accept;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_key  = KEY_WIDTH'(req_entry_key);
   assign req_data = DATA_WIDTH'(req_entry_data);
   assign accept   = req_valid && req_ready;

   // Position from the head folds back into the ring with one subtract,
   // valid whenever the position lies below the occupancy.
   assign edit_sum  = SUM_W'(head_ff) + SUM_W'(req_position);
   assign edit_slot = (edit_sum >= SUM_W'(DEPTH)) ? PTR_W'(edit_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(edit_sum);

   fqks_ram #(
      .DEPTH      (DEPTH),
      .KEY_WIDTH  (KEY_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (req_key),
      .wr_data (req_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SQ_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         scan_ff   <= '0;
         issued_ff <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         scan_ff   <= scan_in;
         issued_ff <= issued_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      scan_in   = scan_ff;
      issued_in = issued_ff;
      key_in    = key_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_en     = 1'b0;
      rd_addr   = scan_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      result.status    = ST_OK;
      result.read_data = '0;

      unique case (state_ff)
         SQ_IDLE: begin
            req_ready = rsp_free;
            if (req_valid && rsp_free) begin
               done = 1'b1;
               unique case (op_type'(req_operation))
                  OP_PUSH: begin
                     if (occ_ff == OCC_W'(DEPTH)) begin
                        result.status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = tail_ff;
                        tail_in = ring_next(tail_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (occ_ff == '0) begin
                        result.status = ST_EMPTY;
                     end else begin
                        head_in = ring_next(head_ff);
                        occ_in  = occ_ff - 1'b1;
                     end
                  end
                  OP_PEEK: begin
                     if (occ_ff == '0) begin
                        result.status = ST_EMPTY;
                     end else begin
                        done     = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = SQ_PEEK;
                     end
                  end
                  OP_CLEAR: begin
                     if (occ_ff == '0) begin
                        result.status = ST_EMPTY;
                     end
                     head_in = '0;
                     tail_in = '0;
                     occ_in  = '0;
                  end
                  OP_SEARCH: begin
                     if (occ_ff == '0) begin
                        result.status = ST_EMPTY;
                     end else begin
                        done      = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = head_ff;
                        scan_in   = ring_next(head_ff);
                        issued_in = OCC_W'(1);
                        key_in    = req_key;
                        state_in  = SQ_SEARCH;
                     end
                  end
                  OP_EDIT: begin
                     if (occ_ff == '0) begin
                        result.status = ST_EMPTY;
                     end else if (CMP_W'(req_position) >= CMP_W'(occ_ff)) begin
                        result.status = ST_BAD_INDEX;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = edit_slot;
                     end
                  end
                  default: begin
                     result.status = ST_OK;
                  end
               endcase
            end
         end
         SQ_PEEK: begin
            done             = 1'b1;
            result.read_data = DATA_PORT_W'(rd_data);
            state_in         = SQ_IDLE;
         end
         SQ_SEARCH: begin
            // One entry read per cycle; the entry read last cycle is compared now.
            if (rd_key == key_ff) begin
               done             = 1'b1;
               result.read_data = DATA_PORT_W'(rd_data);
               state_in         = SQ_IDLE;
            end else if (issued_ff == occ_ff) begin
               done          = 1'b1;
               result.status = ST_NOT_FOUND;
               state_in      = SQ_IDLE;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = scan_ff;
               scan_in   = ring_next(scan_ff);
               issued_in = issued_ff + 1'b1;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase

      result.entry_count = COUNT_W'(occ_in);
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy exceeds the queue depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with head and tail apart");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_SEARCH |-> (issued_ff != '0) && (issued_ff <= occ_ff))
      else $error("search has read outside the occupied entries");

   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation != OP_PEEK) && (req_operation != OP_SEARCH) |-> done)
      else $error("single-cycle operation did not complete at once");

   a_peek_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_PEEK |-> done)
      else $error("peek did not complete after the memory read");

endmodule

/* design/fifo_queue_with_key_search_top.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key search - top level
// Bounded ring of key and data entries with push, pop, peek, clear, search
// by key and overwrite by position; one response per request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  operation, entry_key, entry_data,
//                                             position
//   rsp_      out        rsp_valid/rsp_ready  status, read_data, entry_count
//
// Push, pop, clear, edit and unused operation codes complete in the cycle the
// request transaction is accepted. Peek completes after the registered memory
// read of the head entry. A search compares at most DEPTH entries and stops
// at the first match: the entry memory's single read port delivers one entry
// per cycle.
// Reset is synchronous and active high; it empties the queue. Stored entries
// are not cleared, as only occupied entries are ever read.
// A new request is taken only when the controller is idle and the response
// register is empty or being drained, so a stalled response holds back the
// next request but never an operation already under way.
//
module fifo_queue_with_key_search_top
   import fqks_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned KEY_WIDTH  = 32,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [KEY_PORT_W-1:0]  req_entry_key,
   input  logic [DATA_PORT_W-1:0] req_entry_data,
   input  logic [POS_W-1:0]       req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [DATA_PORT_W-1:0] rsp_read_data,
   output logic [COUNT_W-1:0]     rsp_entry_count
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_free;
   logic       done;
   result_type result;

   // The response register is free when empty or when its transaction
   // completes in this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fqks_ctrl #(
      .DEPTH      (DEPTH),
      .KEY_WIDTH  (KEY_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_entry_key  (req_entry_key),
      .req_entry_data (req_entry_data),
      .req_position   (req_position),
      .rsp_free       (rsp_free),
      .done           (done),
      .result         (result)
   );

   // A finished operation always finds the register free, since its request
   // was only taken while the register was free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_entry_count = rsp_ff.entry_count;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> rsp_free)
      else $error("result produced while a response is still held");

   a_hold_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> rsp_free)
      else $error("request taken while the response register is blocked");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid)
      else $error("completed operation did not reach the response port");

endmodule
